/* rtl/core/http_chunked_body_decoder_core_defines.svh */
// assertion macros for the chunked body decoder core
// used by the top level; no dependencies
`ifndef HTTP_CHUNKED_BODY_DECODER_CORE_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define HCBD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hcbd check failed");

// next-cycle implication, checked outside reset
`define HCBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hcbd check failed");

`endif

/* rtl/core/hcbd_pkg.sv */
// shared types, constants and character helpers for the chunked body decoder
// no dependencies
`timescale 1ns / 1ps

package hcbd_pkg;

  localparam int LENGTH_BITS = 32;
  localparam int BYTE_W      = 8;

  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
  localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    PH_SIZE = 2'd0,
    PH_DATA = 2'd1,
    PH_TAIL = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t                 phase;
    logic [LENGTH_BITS-1:0] count;
    logic                   digit_seen;
    logic                   number_closed;
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_body;
  } result_t;

  localparam state_t STATE_RESET = '{phase: PH_SIZE, count: '0,
                                     digit_seen: 1'b0, number_closed: 1'b0};

  // hex digit decode: is_hex flags a digit, value its nibble
  function automatic logic is_hex(input logic [BYTE_W-1:0] c);
    logic r;
    r = ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66)) ||
        ((c >= 8'h41) && (c <= 8'h46));
    return r;
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] v;
    if (c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

  function automatic logic is_blank(input logic [BYTE_W-1:0] c);
    logic r;
    r = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_VT) ||
        (c == CH_FF);
    return r;
  endfunction

endpackage

/* rtl/core/hcbd_if.sv */
// valid/ready channel interfaces for the body byte stream and the payload stream
// depends on hcbd_pkg
`timescale 1ns / 1ps

interface hcbd_in_if;
  logic                       valid;
  logic                       ready;
  logic [hcbd_pkg::BYTE_W-1:0] in_byte;
  logic                       start_of_body;

  modport source (output valid, output in_byte, output start_of_body, input ready);
  modport sink   (input valid, input in_byte, input start_of_body, output ready);
endinterface

interface hcbd_out_if;
  logic                       valid;
  logic                       ready;
  logic [hcbd_pkg::BYTE_W-1:0] data_byte;
  logic                       end_of_body;

  modport source (output valid, output data_byte, output end_of_body, input ready);
  modport sink   (input valid, input data_byte, input end_of_body, output ready);
endinterface

/* rtl/core/hcbd_step.sv */
// per-byte parser step: next parser state and optional result for one body byte
// depends on hcbd_pkg
`timescale 1ns / 1ps

module hcbd_step (
  input  hcbd_pkg::state_t                cur,
  input  logic [hcbd_pkg::BYTE_W-1:0]     in_byte,
  input  logic                            start_of_body,
  output hcbd_pkg::state_t                nxt,
  output hcbd_pkg::result_t               res
);
  import hcbd_pkg::*;

  state_t                 s;
  logic                   is_lf;
  logic                   size_bad;
  logic [LENGTH_BITS-1:0] acc;
  logic [LENGTH_BITS-1:0] dec;

  // restart clears the parser before the byte is looked at
  assign s        = start_of_body ? STATE_RESET : cur;
  assign is_lf    = (in_byte == CH_LF);
  assign size_bad = !s.digit_seen || (s.count == '0);
  // top nibble set means the shift would overflow: saturate
  assign acc = (s.count[LENGTH_BITS-1 -: 4] != 4'd0) ? '1 :
               {s.count[LENGTH_BITS-5:0], hex_nibble(in_byte)};
  assign dec = (s.count != '0) ? s.count - 1'b1 : '0;

  // next state
  always_comb begin
    nxt = s;
    unique case (s.phase)
      PH_SIZE: begin
        if (is_lf) begin
          if (size_bad) begin
            nxt       = STATE_RESET;
            nxt.phase = PH_DONE;
          end else begin
            nxt.phase         = PH_DATA;
            nxt.digit_seen    = 1'b0;
            nxt.number_closed = 1'b0;
          end
        end else if (!s.number_closed) begin
          if (is_hex(in_byte)) begin
            nxt.count      = acc;
            nxt.digit_seen = 1'b1;
          end else if (!(is_blank(in_byte) && !s.digit_seen)) begin
            nxt.number_closed = 1'b1;
          end
        end
      end
      PH_DATA: begin
        nxt.count = dec;
        if (dec == '0) begin
          nxt.phase = PH_TAIL;
        end
      end
      PH_TAIL: begin
        if (is_lf) begin
          nxt = STATE_RESET;
        end
      end
      PH_DONE: begin
        nxt = s;
      end
      default: begin
        nxt = s;
      end
    endcase
  end

  // result
  always_comb begin
    res = '{valid: 1'b0, data_byte: '0, end_of_body: 1'b0};
    unique case (s.phase)
      PH_SIZE: begin
        if (is_lf && size_bad) begin
          res.valid       = 1'b1;
          res.end_of_body = 1'b1;
        end
      end
      PH_DATA: begin
        res.valid     = 1'b1;
        res.data_byte = in_byte;
      end
      PH_TAIL, PH_DONE: begin
        res.valid = 1'b0;
      end
      default: begin
        res.valid = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/core/http_chunked_body_decoder_core.sv */
// HTTP chunked body decoder: one body byte in per request, zero or one payload
// item out. Each accepted byte lands in an input register; the parser step then
// runs combinationally against the parser state and writes the result register.
// The block takes one byte every cycle as long as the result side keeps up, so
// throughput is one byte per clock, and a result passes through the input register
// and then the result register. A byte that yields no result (size line, CR LF
// after a chunk, anything after the end) still advances the state but never waits
// on the result side. Chunk sizes are hex, saturating at 2^LENGTH_BITS - 1; a zero
// size or a size line with no digits produces one end marker (data_byte 0,
// end_of_body 1) and all later bytes are dropped until start_of_body is seen.
// depends on hcbd_pkg, hcbd_if, hcbd_step and the assertion macro header
`timescale 1ns / 1ps
`include "http_chunked_body_decoder_core_defines.svh"

module http_chunked_body_decoder_core (
  input  logic        clk,
  input  logic        rst,
  hcbd_in_if.sink     body,
  hcbd_out_if.source  payload
);
  import hcbd_pkg::*;

  // input register
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_start;

  // parser state
  state_t state;
  state_t state_next;

  // result register
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_end;

  result_t step_res;
  logic    advance;
  logic    out_free;
  logic    end_emit;

  hcbd_step u_step (
    .cur           (state),
    .in_byte       (in_byte),
    .start_of_body (in_start),
    .nxt           (state_next),
    .res           (step_res)
  );

  // result register is free when empty or being drained this cycle
  assign out_free = !out_valid || payload.ready;
  // a byte with no result never stalls; one with a result needs a free slot
  assign advance  = in_valid && (!step_res.valid || out_free);
  // input register reloads when empty or when its byte moves on
  assign body.ready = !in_valid || advance;
  // end marker leaving the parser this cycle
  assign end_emit = advance && step_res.valid && step_res.end_of_body;

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (body.ready) begin
      in_valid <= body.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (body.ready && body.valid) begin
      in_byte  <= body.in_byte;
      in_start <= body.start_of_body;
    end
  end

  // parser state updates once per byte that moves through
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && step_res.valid) begin
      out_valid <= 1'b1;
    end else if (payload.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_res.valid) begin
      out_byte <= step_res.data_byte;
      out_end  <= step_res.end_of_body;
    end
  end

  assign payload.valid       = out_valid;
  assign payload.data_byte   = out_byte;
  assign payload.end_of_body = out_end;

  // end marker always carries a zero byte
  `HCBD_ASSERT_NOW(a_end_zero, clk, rst, out_valid && out_end, out_byte == '0)
  // payload phase never holds an exhausted count
  `HCBD_ASSERT_NOW(a_data_count, clk, rst, state.phase == PH_DATA, state.count != '0)
  // an emitted end marker leaves the parser finished
  `HCBD_ASSERT_NEXT(a_end_done, clk, rst, end_emit, state.phase == PH_DONE)

endmodule
